// File: sv/trm_pkg.sv
// ----------------------------------------------------------------------------
// trm_pkg: shared types and constants for the translation region manager
// Transaction payloads, request and status codes, and the packet that
// travels along the row of region cells.
// ----------------------------------------------------------------------------
package trm_pkg;

   // Table geometry
   localparam int REGION_COUNT = 32;
   localparam int CELL_IDX_W   = 5;

   // Register indexes on the configuration port
   localparam logic CSR_PAGE_SHIFT   = 1'b0;
   localparam logic CSR_REGION_LIMIT = 1'b1;

   // Reset values of the configuration registers
   localparam logic [4:0] PAGE_SHIFT_RESET   = 5'd12;
   localparam logic [5:0] REGION_LIMIT_RESET = 6'd32;

   typedef enum logic [1:0] {
      OP_FIND     = 2'd0,
      OP_VALIDATE = 2'd1,
      OP_MAP      = 2'd2,
      OP_UNMAP    = 2'd3
   } trm_op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_MISALIGNED = 2'd1,
      ST_REJECT     = 2'd2,
      ST_ACTIVE     = 2'd3
   } trm_status_type;

   // Request transaction
   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  region_index;
      logic [31:0] logical_base;
      logic [63:0] physical_base;
      logic [31:0] span_bytes;
   } trm_req_type;

   // Response transaction
   typedef struct packed {
      trm_status_type status;
      logic [4:0]     found_index;
      logic [31:0]    start_page;
      logic [32:0]    end_page;
      logic [63:0]    page_delta;
      logic [5:0]     active_total;
   } trm_rsp_type;

   // Packet handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic                  act;          // cells may search or modify
      trm_op_type            op;
      logic [7:0]            region_index;
      logic [31:0]           logical_base;
      logic [31:0]           span_bytes;
      logic                  found;        // a free region was located
      logic [CELL_IDX_W-1:0] found_index;
      logic                  hit;          // overlap seen, or target was enabled
   } trm_pkt_type;

endpackage

// File: sv/trm_cell.sv
// ----------------------------------------------------------------------------
// trm_cell: one region slot of the translation region manager
// Holds the enable bit, logical base and span of one region, updates the
// packet passing through and hands it, registered, to the next cell.
// ----------------------------------------------------------------------------
module trm_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [trm_pkg::CELL_IDX_W-1:0]  cell_index,
   input  logic [5:0]                      region_limit,
   input  trm_pkg::trm_pkt_type            pkt_i,
   output trm_pkg::trm_pkt_type            pkt_o
);

   logic                 enable_ff, enable_in;
   logic [31:0]          base_ff, base_in;
   logic [31:0]          span_ff, span_in;
   trm_pkg::trm_pkt_type pkt_ff, pkt_in;

   logic        in_range;
   logic        targeted;
   logic [32:0] stored_end;
   logic [32:0] req_end;
   logic        overlap;

   assign in_range   = {1'b0, cell_index} < region_limit;
   assign targeted   = pkt_i.region_index == {3'b000, cell_index};
   assign stored_end = {1'b0, base_ff} + {1'b0, span_ff};
   assign req_end    = {1'b0, pkt_i.logical_base} + {1'b0, pkt_i.span_bytes};
   assign overlap    = ({1'b0, pkt_i.logical_base} < stored_end) &&
                       ({1'b0, base_ff} < req_end);

   // Apply the request to this slot and update the packet
   always_comb begin
      enable_in = enable_ff;
      base_in   = base_ff;
      span_in   = span_ff;
      pkt_in    = pkt_i;
      if (pkt_i.valid && pkt_i.act && in_range) begin
         case (pkt_i.op)
            trm_pkg::OP_FIND: begin
               if (!pkt_i.found && !enable_ff) begin
                  pkt_in.found       = 1'b1;
                  pkt_in.found_index = cell_index;
               end
            end
            trm_pkg::OP_VALIDATE: begin
               if (enable_ff && (span_ff != 32'd0) && overlap) begin
                  pkt_in.hit = 1'b1;
               end
            end
            trm_pkg::OP_MAP: begin
               if (targeted) begin
                  pkt_in.hit = enable_ff;
                  enable_in  = 1'b1;
                  base_in    = pkt_i.logical_base;
                  span_in    = pkt_i.span_bytes;
               end
            end
            trm_pkg::OP_UNMAP: begin
               if (targeted) begin
                  pkt_in.hit = enable_ff;
                  enable_in  = 1'b0;
                  base_in    = 32'd0;
                  span_in    = 32'd0;
               end
            end
            default: begin
               pkt_in = pkt_i;
            end
         endcase
      end
   end

   // Control state and packet register
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         pkt_ff    <= '0;
      end else begin
         enable_ff <= enable_in;
         pkt_ff    <= pkt_in;
      end
   end

   // Region record
   always_ff @(posedge clock) begin
      base_ff <= base_in;
      span_ff <= span_in;
   end

   assign pkt_o = pkt_ff;

endmodule

// File: sv/translation_region_manager.sv
// ----------------------------------------------------------------------------
// translation_region_manager: table of translation regions
// Find-free, validate, map and unmap requests run along a row of 32 region
// cells; the top level checks alignment, forms the page values and keeps the
// count of active regions.
// ----------------------------------------------------------------------------
//   channel   ports                          direction  handshake
//   request   start, busy, req_data          in         start & !busy
//   response  rsp_valid, rsp_data            out        one-cycle strobe
//   config    csr_we, csr_index, csr_wdata   in         write on csr_we
//
// A request enters the first cell at the edge that accepts it and moves one
// cell per cycle; the response strobe is registered from the packet that leaves
// the last cell, and busy drops at the same edge, so the next request can be
// accepted while the strobe is on the ports. The cell row length sets how long
// a request stays in the row.
// Reset is synchronous: all regions disabled, count zero, registers at their
// defaults. The receiver cannot stall; busy holds off requests meanwhile.
// ----------------------------------------------------------------------------
module translation_region_manager (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  trm_pkg::trm_req_type req_data,
   output logic                 rsp_valid,
   output trm_pkg::trm_rsp_type rsp_data,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [5:0]           csr_wdata
);

   logic [4:0]  page_shift_ff;
   logic [5:0]  region_limit_ff;
   logic        busy_ff, busy_in;
   logic        rsp_valid_ff;
   logic [5:0]  active_ff, active_in;

   trm_pkg::trm_op_type   op_ff;
   logic                  misaligned_ff;
   logic                  bad_index_ff;
   logic [31:0]           spage_ff;
   logic [32:0]           epage_ff;
   logic [63:0]           pshift_ff;
   trm_pkg::trm_rsp_type  rsp_ff, rsp_in;

   trm_pkg::trm_pkt_type  link [trm_pkg::REGION_COUNT+1];
   trm_pkg::trm_pkt_type  head;
   trm_pkg::trm_pkt_type  tail;

   logic                  accept;
   trm_pkg::trm_op_type   req_op;
   logic [31:0]           align_mask;
   logic                  misaligned;
   logic                  bad_index;
   logic [32:0]           last_byte;

   assign accept = start && !busy_ff;
   assign req_op = trm_pkg::trm_op_type'(req_data.req_type);

   // Check alignment and index range of the incoming request
   assign align_mask = 32'((33'd1 << page_shift_ff) - 33'd1);
   assign misaligned = ((req_data.physical_base[31:0] & align_mask) != 32'd0) ||
                       ((req_data.logical_base & align_mask) != 32'd0) ||
                       ((req_data.span_bytes & align_mask) != 32'd0);
   assign bad_index  = (req_data.region_index >= {2'b00, region_limit_ff}) ||
                       (req_data.region_index >= 8'(trm_pkg::REGION_COUNT));
   assign last_byte  = {1'b0, req_data.logical_base} + {1'b0, req_data.span_bytes}
                       - 33'd1;

   // Build the packet for the first cell
   always_comb begin
      head.valid        = accept;
      head.op           = req_op;
      head.region_index = req_data.region_index;
      head.logical_base = req_data.logical_base;
      head.span_bytes   = req_data.span_bytes;
      head.found        = 1'b0;
      head.found_index  = '0;
      head.hit          = 1'b0;
      case (req_op)
         trm_pkg::OP_VALIDATE: head.act = !misaligned;
         trm_pkg::OP_MAP,
         trm_pkg::OP_UNMAP:    head.act = !bad_index;
         default:              head.act = 1'b1;
      endcase
   end

   assign link[0] = head;

   // Row of region cells
   for (genvar i = 0; i < trm_pkg::REGION_COUNT; i++) begin : g_cell
      trm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (trm_pkg::CELL_IDX_W'(i)),
         .region_limit (region_limit_ff),
         .pkt_i        (link[i]),
         .pkt_o        (link[i+1])
      );
   end

   assign tail = link[trm_pkg::REGION_COUNT];

   // Form the response and the new active count when the packet leaves the row
   always_comb begin
      active_in = active_ff;
      rsp_in    = '0;
      case (op_ff)
         trm_pkg::OP_FIND: begin
            if (tail.found) begin
               rsp_in.status      = trm_pkg::ST_OK;
               rsp_in.found_index = tail.found_index;
            end else begin
               rsp_in.status = trm_pkg::ST_REJECT;
            end
         end
         trm_pkg::OP_VALIDATE: begin
            if (misaligned_ff) begin
               rsp_in.status = trm_pkg::ST_MISALIGNED;
            end else if (tail.hit) begin
               rsp_in.status = trm_pkg::ST_REJECT;
            end else begin
               rsp_in.status = trm_pkg::ST_OK;
            end
         end
         trm_pkg::OP_MAP: begin
            if (bad_index_ff) begin
               rsp_in.status = trm_pkg::ST_REJECT;
            end else begin
               rsp_in.start_page = spage_ff;
               rsp_in.end_page   = epage_ff;
               rsp_in.page_delta = pshift_ff - {32'd0, spage_ff};
               if (tail.hit) begin
                  rsp_in.status = trm_pkg::ST_ACTIVE;
               end else begin
                  rsp_in.status = trm_pkg::ST_OK;
                  active_in     = active_ff + 6'd1;
               end
            end
         end
         trm_pkg::OP_UNMAP: begin
            if (bad_index_ff) begin
               rsp_in.status = trm_pkg::ST_REJECT;
            end else begin
               rsp_in.status = trm_pkg::ST_OK;
               if (tail.hit) begin
                  active_in = active_ff - 6'd1;
               end
            end
         end
         default: begin
            rsp_in.status = trm_pkg::ST_OK;
         end
      endcase
      if (!tail.valid) begin
         active_in = active_ff;
      end
      rsp_in.active_total = active_in;
   end

   // Hold off requests while one is in the row
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail.valid) begin
         busy_in = 1'b0;
      end
   end

   // Control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff   <= trm_pkg::PAGE_SHIFT_RESET;
         region_limit_ff <= trm_pkg::REGION_LIMIT_RESET;
         busy_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         active_ff       <= 6'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               trm_pkg::CSR_PAGE_SHIFT:   page_shift_ff   <= csr_wdata[4:0];
               trm_pkg::CSR_REGION_LIMIT: region_limit_ff <= csr_wdata;
               default:                   page_shift_ff   <= page_shift_ff;
            endcase
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= tail.valid;
         active_ff    <= active_in;
      end
   end

   // Capture per-request values at acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_op;
         misaligned_ff <= misaligned;
         bad_index_ff  <= bad_index;
         spage_ff      <= req_data.logical_base >> page_shift_ff;
         epage_ff      <= last_byte >> page_shift_ff;
         pshift_ff     <= req_data.physical_base >> page_shift_ff;
      end
   end

   // Register the response
   always_ff @(posedge clock) begin
      if (tail.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: test/translation_region_manager_tb.sv
// ----------------------------------------------------------------------------
// translation_region_manager_tb: self-checking bench for the region table
// Drives find-free, validate, map and unmap requests: first a short list of
// hand-picked cases, then random traffic over several page shift and region
// limit settings. A predictor keeps its own copy of the table; each response is
// compared field by field against it or, for a marked row, its typed response.
// ----------------------------------------------------------------------------
module translation_region_manager_tb;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 113;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int MAX_REPORTS     = 40;

   // Stimulus row of the directed list; the typed response is used only when
   // the row is marked as such
   typedef struct {
      trm_pkg::trm_req_type req;
      bit                   typed;
      trm_pkg::trm_rsp_type rsp;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   trm_pkg::trm_req_type req_data = '0;
   logic                 rsp_valid;
   trm_pkg::trm_rsp_type rsp_data;
   logic                 csr_we = 1'b0;
   logic                 csr_index = trm_pkg::CSR_PAGE_SHIFT;
   logic [5:0]           csr_wdata = '0;

   // Shadow of the table and its registers
   logic [4:0]  shadow_page_shift;
   logic [5:0]  shadow_region_limit;
   logic [31:0] region_on;
   logic [31:0] region_base [trm_pkg::REGION_COUNT];
   logic [31:0] region_span [trm_pkg::REGION_COUNT];
   logic [5:0]  region_active;

   trm_pkg::trm_rsp_type pending_outcomes [$];
   stim_row_type         directed_rows [$];
   int                   error_count   = 0;
   int                   sent_total    = 0;
   int                   checked_total = 0;
   int                   quiet_cycles  = 0;

   translation_region_manager u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned usable_regions();
      return (shadow_region_limit < 6'd32) ? int'(shadow_region_limit)
                                           : trm_pkg::REGION_COUNT;
   endfunction

   // Work out the response of one request and update the shadow table
   function automatic trm_pkg::trm_rsp_type region_table_outcome(
      input trm_pkg::trm_req_type r);
      trm_pkg::trm_rsp_type o;
      int unsigned lim;
      logic [63:0] pmask;
      logic [32:0] req_end;
      logic [32:0] reg_end;
      logic [32:0] last_byte;
      logic [4:0]  idx;
      o     = '0;
      lim   = usable_regions();
      pmask = (64'd1 << shadow_page_shift) - 64'd1;
      idx   = r.region_index[4:0];
      case (trm_pkg::trm_op_type'(r.req_type))
         trm_pkg::OP_FIND: begin
            o.status = trm_pkg::ST_REJECT;
            for (int j = 0; j < lim; j++) begin
               if (!region_on[j]) begin
                  o.found_index = j[4:0];
                  o.status      = trm_pkg::ST_OK;
                  break;
               end
            end
         end
         trm_pkg::OP_VALIDATE: begin
            if ((r.physical_base & pmask) != 0 ||
                ({32'd0, r.logical_base} & pmask) != 0 ||
                ({32'd0, r.span_bytes} & pmask) != 0) begin
               o.status = trm_pkg::ST_MISALIGNED;
            end else begin
               req_end = {1'b0, r.logical_base} + {1'b0, r.span_bytes};
               for (int j = 0; j < lim; j++) begin
                  if (region_on[j] && region_span[j] != 0) begin
                     reg_end = {1'b0, region_base[j]} + {1'b0, region_span[j]};
                     if ({1'b0, r.logical_base} < reg_end &&
                         {1'b0, region_base[j]} < req_end) begin
                        o.status = trm_pkg::ST_REJECT;
                        break;
                     end
                  end
               end
            end
         end
         trm_pkg::OP_MAP: begin
            if (r.region_index >= lim) begin
               o.status = trm_pkg::ST_REJECT;
            end else begin
               last_byte    = {1'b0, r.logical_base} + {1'b0, r.span_bytes} - 33'd1;
               o.start_page = r.logical_base >> shadow_page_shift;
               o.end_page   = last_byte >> shadow_page_shift;
               o.page_delta = (r.physical_base >> shadow_page_shift) -
                              {32'd0, o.start_page};
               region_base[idx] = r.logical_base;
               region_span[idx] = r.span_bytes;
               if (region_on[idx]) begin
                  o.status = trm_pkg::ST_ACTIVE;
               end else begin
                  region_on[idx] = 1'b1;
                  region_active  = region_active + 6'd1;
               end
            end
         end
         default: begin
            if (r.region_index >= lim) begin
               o.status = trm_pkg::ST_REJECT;
            end else begin
               region_base[idx] = '0;
               region_span[idx] = '0;
               if (region_on[idx]) begin
                  region_on[idx] = 1'b0;
                  region_active  = region_active - 6'd1;
               end
            end
         end
      endcase
      o.active_total = region_active;
      return o;
   endfunction

   function automatic stim_row_type dir_row(input trm_pkg::trm_op_type op,
                                            input logic [7:0] idx,
                                            input logic [31:0] lbase,
                                            input logic [63:0] pbase,
                                            input logic [31:0] span, input bit typed,
                                            input trm_pkg::trm_status_type st,
                                            input logic [4:0] found,
                                            input logic [5:0] active);
      stim_row_type s;
      s.req.req_type       = op;
      s.req.region_index   = idx;
      s.req.logical_base   = lbase;
      s.req.physical_base  = pbase;
      s.req.span_bytes     = span;
      s.typed              = typed;
      s.rsp                = '0;
      s.rsp.status         = st;
      s.rsp.found_index    = found;
      s.rsp.active_total   = active;
      return s;
   endfunction

   // Random request: mostly page-aligned ranges in a narrow window so that
   // overlaps and refills happen often; the rest is raw noise
   function automatic trm_pkg::trm_req_type random_request(input bit fill);
      trm_pkg::trm_req_type r;
      logic [63:0] pmask;
      int unsigned lim;
      int unsigned pick;
      pmask = (64'd1 << shadow_page_shift) - 64'd1;
      lim   = usable_regions();
      pick  = $urandom_range(0, 99);
      if (fill) begin
         r.req_type = (pick < 15) ? trm_pkg::OP_FIND : (pick < 35) ? trm_pkg::OP_VALIDATE :
                      (pick < 90) ? trm_pkg::OP_MAP : trm_pkg::OP_UNMAP;
      end else begin
         r.req_type = (pick < 20) ? trm_pkg::OP_FIND : (pick < 55) ? trm_pkg::OP_VALIDATE :
                      (pick < 80) ? trm_pkg::OP_MAP : trm_pkg::OP_UNMAP;
      end
      case ($urandom_range(0, 11))
         0:       r.region_index = 8'($urandom);
         1:       r.region_index = 8'(lim);
         default: r.region_index = 8'($urandom_range(0, lim - 1));
      endcase
      case ($urandom_range(0, 9))
         0, 1:    r.logical_base = $urandom;
         2:       r.logical_base = $urandom & ~pmask[31:0];
         default: r.logical_base = 32'($urandom_range(0, 63)) << shadow_page_shift;
      endcase
      case ($urandom_range(0, 9))
         0:       r.span_bytes = $urandom;
         1:       r.span_bytes = '0;
         2:       r.span_bytes = '1;
         3:       r.span_bytes = $urandom & ~pmask[31:0];
         default: r.span_bytes = 32'($urandom_range(1, 8)) << shadow_page_shift;
      endcase
      case ($urandom_range(0, 9))
         0:       r.physical_base = {$urandom, $urandom};
         1:       r.physical_base = '1;
         default: r.physical_base = {$urandom, $urandom} & ~pmask;
      endcase
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
   endtask

   // Present one transaction, hold it until accepted, then optionally idle
   task automatic send_request(input trm_pkg::trm_req_type r, input bit typed,
                               input trm_pkg::trm_rsp_type want, input bit allow_gaps);
      trm_pkg::trm_rsp_type predicted;
      req_data <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predicted = region_table_outcome(r);
      pending_outcomes.push_back(typed ? want : predicted);
      sent_total++;
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Write both registers; only called with the block idle
   task automatic set_config(input logic [4:0] shift, input logic [5:0] limit);
      csr_we    <= 1'b1;
      csr_index <= trm_pkg::CSR_PAGE_SHIFT;
      csr_wdata <= {1'b0, shift};
      @(posedge clock);
      csr_index <= trm_pkg::CSR_REGION_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_page_shift   = shift;
      shadow_region_limit = limit;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Check each response against the oldest pending outcome
   always @(posedge clock) begin
      trm_pkg::trm_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            flag_mismatch("response with nothing pending", 64'd1, 64'd0);
         end else begin
            want = pending_outcomes.pop_front();
            checked_total++;
            if (rsp_data.status !== want.status)
               flag_mismatch("status", 64'(rsp_data.status), 64'(want.status));
            if (rsp_data.found_index !== want.found_index)
               flag_mismatch("found_index", 64'(rsp_data.found_index), 64'(want.found_index));
            if (rsp_data.start_page !== want.start_page)
               flag_mismatch("start_page", 64'(rsp_data.start_page), 64'(want.start_page));
            if (rsp_data.end_page !== want.end_page)
               flag_mismatch("end_page", 64'(rsp_data.end_page), 64'(want.end_page));
            if (rsp_data.page_delta !== want.page_delta)
               flag_mismatch("page_delta", rsp_data.page_delta, want.page_delta);
            if (rsp_data.active_total !== want.active_total)
               flag_mismatch("active_total", 64'(rsp_data.active_total),
                             64'(want.active_total));
         end
      end
   end

   // Stop the run if neither side moves a transaction for too long
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("translation_region_manager_tb: errors");
         $finish;
      end
   end

   initial begin
      int unsigned  shift_plan [6] = '{12, 0, 31, 5, 12, 0};
      int unsigned  limit_plan [6] = '{32, 1, 32, 4, 3, 32};
      logic [4:0]   shift;
      logic [5:0]   limit;
      int           tail;
      bit           fill;
      bit           gaps;

      // Reset state of the shadow table
      shadow_page_shift   = trm_pkg::PAGE_SHIFT_RESET;
      shadow_region_limit = trm_pkg::REGION_LIMIT_RESET;
      region_on           = '0;
      region_active       = '0;
      for (int j = 0; j < trm_pkg::REGION_COUNT; j++) begin
         region_base[j] = '0;
         region_span[j] = '0;
      end

      // Directed cases at the reset settings (4 KiB pages, 32 regions)
      directed_rows.push_back(dir_row(trm_pkg::OP_FIND, 0, 0, 0, 0, 1,
                                      trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'h1_0000, 64'h4_0000,
                                      32'h4000, 1, trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'h1_0800, 64'h4_0000,
                                      32'h4000, 1, trm_pkg::ST_MISALIGNED, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'h1_0000, 64'h4_0001,
                                      32'h4000, 1, trm_pkg::ST_MISALIGNED, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'h1_0000, 64'h4_0000,
                                      32'h0FFF, 1, trm_pkg::ST_MISALIGNED, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_MAP, 0, 32'h1_0000, 64'h4_0000,
                                      32'h4000, 0, trm_pkg::ST_OK, 0, 0));
      // remap of an enabled region
      directed_rows.push_back(dir_row(trm_pkg::OP_MAP, 0, 32'h1_0000, 64'h4_0000,
                                      32'h4000, 0, trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'h1_2000, 0, 32'h1000,
                                      1, trm_pkg::ST_REJECT, 0, 1));
      // ranges touching the region from below and above
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'h0_F000, 0, 32'h1000,
                                      0, trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'h1_4000, 0, 32'h1000,
                                      0, trm_pkg::ST_OK, 0, 0));
      // empty requested ranges, inside and outside the region
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'h1_1000, 0, 0, 0,
                                      trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'h2_0000, 0, 0, 0,
                                      trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_MAP, 32, 0, 0, 0, 1,
                                      trm_pkg::ST_REJECT, 0, 1));
      directed_rows.push_back(dir_row(trm_pkg::OP_MAP, 255, '1, '1, '1, 1,
                                      trm_pkg::ST_REJECT, 0, 1));
      directed_rows.push_back(dir_row(trm_pkg::OP_UNMAP, 255, 0, 0, 0, 1,
                                      trm_pkg::ST_REJECT, 0, 1));
      directed_rows.push_back(dir_row(trm_pkg::OP_UNMAP, 5, 0, 0, 0, 1,
                                      trm_pkg::ST_OK, 0, 1));
      // top region with extreme fields; end address runs past 32 bits
      directed_rows.push_back(dir_row(trm_pkg::OP_MAP, 31, 32'hFFFF_F000, '1, '1, 0,
                                      trm_pkg::ST_OK, 0, 0));
      // zero-size region is skipped by the overlap scan
      directed_rows.push_back(dir_row(trm_pkg::OP_MAP, 1, 32'h3_0000, 0, 0, 0,
                                      trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'h3_0000, 0, 32'h1000,
                                      0, trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_FIND, 0, 0, 0, 0, 1,
                                      trm_pkg::ST_OK, 2, 3));
      directed_rows.push_back(dir_row(trm_pkg::OP_VALIDATE, 0, 32'hFFFF_F000, 0, 32'h1000,
                                      1, trm_pkg::ST_REJECT, 0, 3));
      directed_rows.push_back(dir_row(trm_pkg::OP_UNMAP, 0, 0, 0, 0, 0,
                                      trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_UNMAP, 31, 0, 0, 0, 0,
                                      trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_UNMAP, 1, 0, 0, 0, 0,
                                      trm_pkg::ST_OK, 0, 0));
      directed_rows.push_back(dir_row(trm_pkg::OP_FIND, 0, 0, 0, 0, 1,
                                      trm_pkg::ST_OK, 0, 0));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp,
                      1'b1);
      start <= 1'b0;

      // Random phases; the table carries over between settings
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         if (p < 6) begin
            shift = 5'(shift_plan[p]);
            limit = 6'(limit_plan[p]);
         end else begin
            shift = 5'($urandom_range(0, 31));
            limit = 6'($urandom_range(1, 32));
         end
         set_config(shift, limit);
         fill = (p == 2 || p == 5);
         gaps = (p != PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_request(random_request(fill), 1'b0, '0, gaps);
         start <= 1'b0;
      end

      // Drain the outstanding responses
      tail = 0;
      while (pending_outcomes.size() != 0 && tail < WATCHDOG_LIMIT) begin
         @(posedge clock);
         tail++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0)
         flag_mismatch("responses never arrived", 64'(pending_outcomes.size()), 64'd0);

      $display("Sent %0d requests (%0d directed) across %0d register settings,",
               sent_total, directed_rows.size(), PHASES + 1);
      $display("checked %0d responses, %0d mismatches.", checked_total, error_count);
      if (error_count == 0)
         $display("translation_region_manager_tb: clean");
      else
         $display("translation_region_manager_tb: errors");
      $finish;
   end

endmodule
